@@ hw/rtl/sbc_pkg.sv @@
package sbc_pkg;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_DIGITS  = 20;

  localparam logic [6:0]  BATCH_DEPTH    = 7'd64;
  localparam logic [63:0] SAFE_SEQ_MAX   = 64'd9007199254740991;
  localparam logic [22:0] FIXED_OVERHEAD = 23'd64;

  localparam logic [6:0]  RST_MAX_SAMPLES = 7'd64;
  localparam logic [22:0] RST_MAX_BYTES   = 23'd65536;
  localparam logic [15:0] RST_MAX_LATENCY = 16'd100;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SAMPLES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BYTES   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LATENCY = 2'd2;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SMP_ACCEPTED = 2'd0,
    SMP_EMPTY    = 2'd1,
    SMP_GAP      = 2'd2
  } sample_status_t;

  typedef enum logic [2:0] {
    CAUSE_TASK    = 3'd0,
    CAUSE_BYTES   = 3'd1,
    CAUSE_COUNT   = 3'd2,
    CAUSE_LATENCY = 3'd3,
    CAUSE_REQUEST = 3'd4
  } cause_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_BATCH  = 1'b1
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic [63:0] seq;
    logic [15:0] task_tag;
    logic [15:0] sample_bytes;
    logic        empty;
    logic [4:0]  digits;
    logic        seq_safe;
  } sbc_item_t;

  typedef struct packed {
    logic [6:0]  cap;
    logic [22:0] limit;
    logic [15:0] latency;
  } sbc_cfg_t;

  typedef struct packed {
    kind_t          kind;
    sample_status_t status;
    cause_t         cause;
    logic [63:0]    first_seq;
    logic [63:0]    last_seq;
    logic [6:0]     sample_count;
    logic [21:0]    payload_bytes;
    logic [22:0]    batch_bytes;
    logic           last;
  } sbc_result_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = '1;
    endcase
    return p;
  endfunction

  // overhead + both digit counts + payload + separators
  function automatic logic [22:0] proj_size(input logic [4:0] dig_a, input logic [4:0] dig_b,
                                            input logic [21:0] pay, input logic [6:0] extra);
    return FIXED_OVERHEAD + 23'(dig_a) + 23'(dig_b) + 23'(pay) + 23'(extra);
  endfunction

endpackage

@@ hw/rtl/sbc_front.sv @@
module sbc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sequence_req, task_tag, sample_bytes
  input  logic [sbc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic [sbc_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output sbc_pkg::sbc_item_t                q_item
);
  import sbc_pkg::*;

  logic              fv_r;
  logic              fv_nxt;
  sbc_item_t         item_r;
  sbc_item_t         item_nxt;
  logic              in_acc;
  logic [MAX_DIGITS-2:0] ge;
  logic [63:0]       seq_in;

  assign in_tready = !fv_r || !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign q_push    = fv_r && !q_full;
  assign q_item    = item_r;
  assign seq_in    = in_tdata[63:0];

  always_comb begin
    for (int i = 1; i < MAX_DIGITS; i++) begin
      ge[i-1] = (seq_in >= pow10(5'(i)));
    end
    item_nxt.action       = action_t'(in_tuser);
    item_nxt.seq          = seq_in;
    item_nxt.task_tag     = in_tdata[79:64];
    item_nxt.sample_bytes = in_tdata[95:80];
    item_nxt.empty        = (in_tdata[95:80] == 16'd0);
    item_nxt.digits       = 5'd1 + 5'($countones(ge));
    item_nxt.seq_safe     = (seq_in <= SAFE_SEQ_MAX);
    if (in_acc) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end else begin
      fv_nxt = fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ hw/rtl/sbc_queue.sv @@
module sbc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sbc_pkg::sbc_item_t din,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output sbc_pkg::sbc_item_t dout
);
  import sbc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sbc_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hw/rtl/sbc_back.sv @@
module sbc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sbc_pkg::sbc_cfg_t    cfg,
  input  logic                 q_valid,
  input  sbc_pkg::sbc_item_t   q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sbc_pkg::sbc_result_t res
);
  import sbc_pkg::*;

  typedef enum logic [1:0] {
    S_CHECK,
    S_START,
    S_POST,
    S_STATUS
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  held_r, held_nxt;
  logic [63:0] first_r, first_nxt;
  logic [63:0] last_r, last_nxt;
  logic [15:0] task_r, task_nxt;
  logic [21:0] pay_r, pay_nxt;
  logic [4:0]  first_dig_r, first_dig_nxt;
  logic [4:0]  last_dig_r, last_dig_nxt;
  logic        first_safe_r, first_safe_nxt;
  logic [15:0] lat_r, lat_nxt;
  logic        run_r, run_nxt;
  logic        res_valid_r, res_valid_nxt;
  sbc_result_t res_r, res_nxt;

  logic        can_take;
  logic        go;
  logic        hit;
  logic [63:0] last_inc;
  logic [4:0]  hyp_dig;
  logic [21:0] pay_hyp;
  logic [22:0] size_hyp;
  logic [22:0] size_cur;
  logic        safe_hyp;
  logic        safe_cur;
  logic        reach_hyp;
  logic        reach_cur;
  logic        task_change;
  logic        seq_gap;
  logic        do_start;
  logic        do_append;
  logic        do_clear;
  logic        do_emit;
  sbc_result_t desc;
  sbc_result_t stat;
  sbc_result_t pick;

  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    can_take    = !res_valid_r || res_ready;
    go          = q_valid && can_take;
    hit         = (held_r != '0);
    last_inc    = last_r + 64'd1;
    hyp_dig     = last_dig_r + {4'd0, (last_inc == pow10(last_dig_r))};
    pay_hyp     = pay_r + 22'(q_item.sample_bytes);
    size_hyp    = proj_size(first_dig_r, hyp_dig, pay_hyp, held_r);
    size_cur    = proj_size(first_dig_r, last_dig_r, pay_r, held_r - 7'd1);
    safe_hyp    = first_safe_r && (last_r < SAFE_SEQ_MAX);
    safe_cur    = first_safe_r && (last_r <= SAFE_SEQ_MAX);
    reach_hyp   = safe_hyp && (size_hyp >= cfg.limit);
    reach_cur   = safe_cur && (size_cur >= cfg.limit);
    task_change = hit && (q_item.task_tag != task_r);
    seq_gap     = hit && (q_item.seq != last_inc);

    desc = '{kind: KIND_BATCH, status: SMP_ACCEPTED, cause: CAUSE_TASK,
             first_seq: first_r, last_seq: last_r, sample_count: held_r,
             payload_bytes: pay_r, batch_bytes: (safe_cur ? size_cur : 23'd0),
             last: 1'b0};
    stat = '{kind: KIND_STATUS, status: SMP_ACCEPTED, cause: CAUSE_TASK,
             first_seq: 64'd0, last_seq: 64'd0, sample_count: 7'd0,
             payload_bytes: 22'd0, batch_bytes: 23'd0, last: 1'b1};

    state_nxt      = state_r;
    held_nxt       = held_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    task_nxt       = task_r;
    pay_nxt        = pay_r;
    first_dig_nxt  = first_dig_r;
    last_dig_nxt   = last_dig_r;
    first_safe_nxt = first_safe_r;
    lat_nxt        = lat_r;
    run_nxt        = run_r;
    res_valid_nxt  = res_valid_r && !res_ready;
    res_nxt        = res_r;
    q_pop          = 1'b0;
    do_start       = 1'b0;
    do_append      = 1'b0;
    do_clear       = 1'b0;
    do_emit        = 1'b0;
    pick           = desc;

    if (go) begin
      unique case (state_r)
        S_CHECK: begin
          unique case (q_item.action)
            ACT_SAMPLE: begin
              if (q_item.empty) begin
                do_emit     = 1'b1;
                pick        = stat;
                pick.status = SMP_EMPTY;
                q_pop       = 1'b1;
              end else if (task_change) begin
                do_emit    = 1'b1;
                pick.cause = CAUSE_TASK;
                do_clear   = 1'b1;
                state_nxt  = S_START;
              end else if (seq_gap) begin
                do_emit     = 1'b1;
                pick        = stat;
                pick.status = SMP_GAP;
                q_pop       = 1'b1;
              end else if (hit && reach_hyp) begin
                do_emit    = 1'b1;
                pick.cause = CAUSE_BYTES;
                do_clear   = 1'b1;
                state_nxt  = S_START;
              end else if (hit) begin
                do_append = 1'b1;
                state_nxt = S_POST;
              end else begin
                do_start  = 1'b1;
                state_nxt = S_POST;
              end
            end
            ACT_TICK: begin
              q_pop = 1'b1;
              if (run_r) begin
                if (lat_r <= 16'd1) begin
                  do_clear   = 1'b1;
                  do_emit    = hit;
                  pick.cause = CAUSE_LATENCY;
                  pick.last  = 1'b1;
                end else begin
                  lat_nxt = lat_r - 16'd1;
                end
              end
            end
            ACT_FLUSH: begin
              q_pop      = 1'b1;
              do_clear   = 1'b1;
              do_emit    = hit;
              pick.cause = CAUSE_REQUEST;
              pick.last  = 1'b1;
            end
            ACT_CLEAR: begin
              q_pop    = 1'b1;
              do_clear = 1'b1;
            end
          endcase
        end
        S_START: begin
          do_start  = 1'b1;
          state_nxt = S_POST;
        end
        S_POST: begin
          if (held_r >= cfg.cap) begin
            do_emit    = 1'b1;
            pick.cause = CAUSE_COUNT;
            do_clear   = 1'b1;
            state_nxt  = S_STATUS;
          end else if (reach_cur) begin
            do_emit    = 1'b1;
            pick.cause = CAUSE_BYTES;
            do_clear   = 1'b1;
            state_nxt  = S_STATUS;
          end else begin
            do_emit   = 1'b1;
            pick      = stat;
            q_pop     = 1'b1;
            state_nxt = S_CHECK;
          end
        end
        S_STATUS: begin
          do_emit   = 1'b1;
          pick      = stat;
          q_pop     = 1'b1;
          state_nxt = S_CHECK;
        end
      endcase
    end

    if (do_clear) begin
      held_nxt = '0;
      run_nxt  = 1'b0;
      lat_nxt  = '0;
    end
    if (do_start) begin
      held_nxt       = 7'd1;
      first_nxt      = q_item.seq;
      last_nxt       = q_item.seq;
      task_nxt       = q_item.task_tag;
      pay_nxt        = 22'(q_item.sample_bytes);
      first_dig_nxt  = q_item.digits;
      last_dig_nxt   = q_item.digits;
      first_safe_nxt = q_item.seq_safe;
      lat_nxt        = cfg.latency;
      run_nxt        = 1'b1;
    end
    if (do_append) begin
      held_nxt     = held_r + 7'd1;
      pay_nxt      = pay_hyp;
      last_nxt     = last_inc;
      last_dig_nxt = hyp_dig;
    end
    if (do_emit) begin
      res_valid_nxt = 1'b1;
      res_nxt       = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CHECK;
      held_r      <= '0;
      lat_r       <= '0;
      run_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      lat_r       <= lat_nxt;
      run_r       <= run_nxt;
      res_valid_r <= res_valid_nxt;
    end
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    task_r       <= task_nxt;
    pay_r        <= pay_nxt;
    first_dig_r  <= first_dig_nxt;
    last_dig_r   <= last_dig_nxt;
    first_safe_r <= first_safe_nxt;
    res_r        <= res_nxt;
  end

  a_timer_needs_batch: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> hit)
    else $error("timer running with no open batch");

  a_item_held_mid_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CHECK) |-> q_valid)
    else $error("sequencer mid-item without a queued item");

  a_post_has_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST) |-> hit)
    else $error("post-append check with empty batch");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (res_r.kind == KIND_STATUS)) |-> res_r.last)
    else $error("sample status not marked last");

  a_batch_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (res_r.kind == KIND_BATCH)) |-> (res_r.sample_count != 7'd0))
    else $error("empty batch descriptor");

endmodule

@@ hw/rtl/sample_batch_coalescer.sv @@
// path: an accepted item is registered in the front end, held in a 2-entry queue that
//   keeps the input accepting, and reported through the back end's result register
// back-end states: S_CHECK alone for a tick, flush request, clear, empty or gap sample;
//   other samples S_CHECK, S_START if S_CHECK flushed, S_POST, S_STATUS if S_POST flushed
// reset: rst_n synchronous active low; empties batch, queue and output register,
//   registers return to max_samples 64, max_bytes 65536, max_latency_ticks 100
module sample_batch_coalescer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sequence_req[63:0], task_tag[79:64], sample_bytes[95:80]
  input  logic [sbc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action[1:0]
  input  logic [sbc_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], flush_cause[4:2], first_seq[68:5], last_seq[132:69],
  // sample_count[139:133], payload_bytes[161:140], batch_bytes[184:162], zeros above
  output logic [sbc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [sbc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sbc_pkg::*;

  sbc_cfg_t    cfg_r;
  logic [6:0]  cap_wr;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  sbc_item_t   front_item;
  sbc_item_t   head_item;
  sbc_result_t res;

  // clamp sample limit to 1..depth
  always_comb begin
    if (cfg_wdata[6:0] == 7'd0) begin
      cap_wr = 7'd1;
    end else if (cfg_wdata[6:0] > BATCH_DEPTH) begin
      cap_wr = BATCH_DEPTH;
    end else begin
      cap_wr = cfg_wdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{cap: RST_MAX_SAMPLES, limit: RST_MAX_BYTES, latency: RST_MAX_LATENCY};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_SAMPLES: cfg_r.cap     <= cap_wr;
        CFG_MAX_BYTES:   cfg_r.limit   <= (cfg_wdata == '0) ? 23'd1 : cfg_wdata;
        CFG_MAX_LATENCY: cfg_r.latency <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  sbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (front_item)
  );

  sbc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (head_item)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0, res.batch_bytes, res.payload_bytes, res.sample_count,
                      res.last_seq, res.first_seq, res.cause, res.status};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
